// File: design/nur_pkg.sv
// shared types and constants for the nur victim chooser
package nur_pkg;

	localparam int ACTION_W  = 3;
	localparam int BLOCK_W   = 6;
	localparam int COUNT_W   = 16;
	localparam int GROUP_SZ  = 8;
	localparam int OFF_W     = 3;
	localparam int NUM_MASKS = 4;

	localparam logic [ACTION_W-1:0] ACT_READ       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REPLACE    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_STATUS     = 3'd4;

	// search masks in priority order
	localparam int MASK_INV = 0;
	localparam int MASK_W0  = 1;
	localparam int MASK_W1  = 2;
	localparam int MASK_W2  = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic REG_DEREF_PERIOD = 1'b0;

	typedef struct packed {
		logic take;
		logic exec;
		logic search;
		logic load_out;
	} nur_cmd_t;

	typedef struct packed {
		logic is_replace;
		logic out_free;
	} nur_sts_t;

endpackage

// File: design/nur_ctrl.sv
// controller state machine sequencing each transaction
module nur_ctrl
	import nur_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  nur_sts_t sts,
	output nur_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SRCH,
		ST_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		item_ready   = (state_q == ST_IDLE) || ((state_q == ST_FIN) && sts.out_free);
		cmd.take     = item_valid && item_ready;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.search   = (state_q == ST_SRCH);
		cmd.load_out = (state_q == ST_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= sts.is_replace ? ST_SRCH : ST_FIN;
				end
				ST_SRCH: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= cmd.take ? ST_EXEC : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/nur_datapath.sv
// flag vectors, access counter, victim search and result register
module nur_datapath
	import nur_pkg::*;
#(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nur_cmd_t            cmd,
	output nur_sts_t            sts,
	input  logic [COUNT_W-1:0]  deref_period,
	input  logic [ACTION_W-1:0] action,
	input  logic [BLOCK_W-1:0]  block_index,
	input  logic                valid_bit,
	input  logic                dirty_bit,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [BLOCK_W-1:0]  victim_index,
	output logic                victim_found,
	output logic                period_reset
);

	localparam int NUM_GROUPS = (NUM_BLOCKS + GROUP_SZ - 1) / GROUP_SZ;
	localparam int PAD        = NUM_GROUPS * GROUP_SZ;
	localparam int GW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int FULL_W     = GW + OFF_W;

	logic [ACTION_W-1:0]   act_q;
	logic [BLOCK_W-1:0]    blk_q;
	logic                  v_q;
	logic                  d_q;

	logic [NUM_BLOCKS-1:0] valid_q;
	logic [NUM_BLOCKS-1:0] dirty_q;
	logic [NUM_BLOCKS-1:0] ref_q;
	logic [COUNT_W-1:0]    count_q;

	logic [NUM_MASKS-1:0][NUM_GROUPS-1:0]            grp_hit_s1;
	logic [NUM_MASKS-1:0][NUM_GROUPS-1:0][OFF_W-1:0] grp_off_s1;

	logic [BLOCK_W-1:0] res_idx_q;
	logic               res_found_q;
	logic               res_preset_q;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_idx_q;
	logic               out_found_q;
	logic               out_preset_q;

	logic [NUM_BLOCKS-1:0] hit_vec;
	logic                  is_access;
	logic [COUNT_W-1:0]    count_inc;
	logic [COUNT_W-1:0]    count_d;
	logic                  clear_ref;

	logic [NUM_MASKS-1:0][PAD-1:0]                   mask;
	logic [NUM_MASKS-1:0][NUM_GROUPS-1:0]            grp_hit;
	logic [NUM_MASKS-1:0][NUM_GROUPS-1:0][OFF_W-1:0] grp_off;

	logic [NUM_MASKS-1:0]             m_found;
	logic [NUM_MASKS-1:0][FULL_W-1:0] m_idx;
	logic [FULL_W-1:0]                pick;
	logic [FULL_W+BLOCK_W-1:0]        pick_wide;

	assign sts.is_replace = (act_q == ACT_REPLACE);
	assign sts.out_free   = !out_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q <= action;
			blk_q <= block_index;
			v_q   <= valid_bit;
			d_q   <= dirty_bit;
		end
	end

	// one-hot select of the addressed block, empty when out of range
	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			hit_vec[i] = (32'(blk_q) == 32'(i));
		end
	end

	always_comb begin
		is_access = (act_q == ACT_READ) || (act_q == ACT_WRITE);
		count_inc = count_q + 16'd1;
		count_d   = count_q;
		clear_ref = 1'b0;
		if (is_access) begin
			if (deref_period == '0) begin
				if (count_q != COUNT_MAX) count_d = count_inc;
			end else if (count_inc == deref_period) begin
				count_d   = '0;
				clear_ref = 1'b1;
			end else begin
				count_d = count_inc;
			end
		end else if (act_q == ACT_INVALIDATE) begin
			if (deref_period != '0) begin
				count_d   = '0;
				clear_ref = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			ref_q   <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
			if (is_access) begin
				ref_q <= (clear_ref ? '0 : ref_q) | hit_vec;
			end else if (clear_ref) begin
				ref_q <= '0;
			end
			if (act_q == ACT_STATUS) begin
				valid_q <= (valid_q & ~hit_vec) | (hit_vec & {NUM_BLOCKS{v_q}});
				dirty_q <= (dirty_q & ~hit_vec) | (hit_vec & {NUM_BLOCKS{d_q}});
			end
		end
	end

	// first level: lowest set bit inside each group of eight
	always_comb begin
		mask[MASK_INV] = PAD'(~valid_q);
		mask[MASK_W0]  = PAD'(~ref_q & ~dirty_q);
		mask[MASK_W1]  = PAD'(~ref_q & dirty_q);
		mask[MASK_W2]  = PAD'(ref_q & ~dirty_q);
		for (int m = 0; m < NUM_MASKS; m++) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_hit[m][g] = 1'b0;
				grp_off[m][g] = '0;
				for (int b = GROUP_SZ - 1; b >= 0; b--) begin
					if (mask[m][g*GROUP_SZ + b]) begin
						grp_hit[m][g] = 1'b1;
						grp_off[m][g] = OFF_W'(b);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && sts.is_replace) begin
			grp_hit_s1 <= grp_hit;
			grp_off_s1 <= grp_off;
		end
	end

	// second level: lowest hitting group, then mask priority
	always_comb begin
		for (int m = 0; m < NUM_MASKS; m++) begin
			m_found[m] = 1'b0;
			m_idx[m]   = '0;
			for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
				if (grp_hit_s1[m][g]) begin
					m_found[m] = 1'b1;
					m_idx[m]   = {GW'(g), grp_off_s1[m][g]};
				end
			end
		end
		if (m_found[MASK_INV])     pick = m_idx[MASK_INV];
		else if (m_found[MASK_W0]) pick = m_idx[MASK_W0];
		else if (m_found[MASK_W1]) pick = m_idx[MASK_W1];
		else if (m_found[MASK_W2]) pick = m_idx[MASK_W2];
		else                       pick = '0;
		pick_wide = (FULL_W+BLOCK_W)'(pick);
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_idx_q    <= '0;
			res_found_q  <= 1'b0;
			res_preset_q <= clear_ref;
		end else if (cmd.search) begin
			res_idx_q    <= pick_wide[BLOCK_W-1:0];
			res_found_q  <= 1'b1;
			res_preset_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q    <= res_idx_q;
			out_found_q  <= res_found_q;
			out_preset_q <= res_preset_q;
		end
	end

	assign result_valid = out_valid_q;
	assign victim_index = out_idx_q;
	assign victim_found = out_found_q;
	assign period_reset = out_preset_q;

endmodule

// File: design/nur_replacement_policy_top.sv
// top level of the nur victim chooser: config register, controller, datapath
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready   action, block_index, valid_bit, dirty_bit
//  result    out        result_valid / result_ready  victim_index, victim_found, period_reset
//  config    in         psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// a transaction passes through the execute and finish states; a replace query adds a
// search state between them, the second level of the registered priority search over groups
// the result sits in an output register, so the next transaction is taken while it waits
// reset clears the flag vectors, the access counter and deref_period at once
// a stalled result holds the controller in its finish state until it is taken
module nur_replacement_policy_top
	import nur_pkg::*;
#(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [ACTION_W-1:0] action,
	input  logic [BLOCK_W-1:0]  block_index,
	input  logic                valid_bit,
	input  logic                dirty_bit,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [BLOCK_W-1:0]  victim_index,
	output logic                victim_found,
	output logic                period_reset,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [COUNT_W-1:0] period_q;
	nur_cmd_t           cmd;
	nur_sts_t           sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_DEREF_PERIOD) begin
			period_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DEREF_PERIOD) ? 32'(period_q) : '0;

	nur_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	nur_datapath #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.deref_period (period_q),
		.action       (action),
		.block_index  (block_index),
		.valid_bit    (valid_bit),
		.dirty_bit    (dirty_bit),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.victim_index (victim_index),
		.victim_found (victim_found),
		.period_reset (period_reset)
	);

	// a replace answer never reports a clearing
	a_found_no_reset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(victim_found && period_reset))
		else $error("victim_found and period_reset both set");

	// non-replace results carry a zero index
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !victim_found) |-> (victim_index == '0))
		else $error("victim_index nonzero without victim_found");

	// the block is busy in the cycle after taking a transaction
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item_ready high right after a transaction");

	// a result is only loaded from the finish state, never while a new item executes
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(cmd.exec || cmd.search))
		else $error("result loaded while busy");

endmodule

// File: tb/tb_nur_replacement_policy_top.sv
// self-checking testbench for the nur victim chooser top level
`timescale 1ns / 1ps

module tb_nur_replacement_policy_top;
	import nur_pkg::*;

	localparam int NUM_BLOCKS  = 64;
	localparam int STALL_LIMIT = 5000;
	localparam int IDLE_PCT    = 38;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] ADDR_DEREF_PERIOD = {REG_DEREF_PERIOD, 2'b00};

	typedef struct packed {
		logic [BLOCK_W-1:0] victim_index;
		logic               victim_found;
		logic               period_reset;
	} outcome_t;

	logic                clk;
	logic                arst_n;
	logic                item_valid;
	logic                item_ready;
	logic [ACTION_W-1:0] action;
	logic [BLOCK_W-1:0]  block_index;
	logic                valid_bit;
	logic                dirty_bit;
	logic                result_valid;
	logic                result_ready;
	logic [BLOCK_W-1:0]  victim_index;
	logic                victim_found;
	logic                period_reset;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	// shadow copy of the block state
	logic [NUM_BLOCKS-1:0] shadow_valid;
	logic [NUM_BLOCKS-1:0] shadow_dirty;
	logic [NUM_BLOCKS-1:0] shadow_ref;
	logic [COUNT_W-1:0]    shadow_count;
	logic [COUNT_W-1:0]    shadow_period;

	outcome_t outcome_q[$];
	outcome_t oldest;
	int       fail_count;
	int       stall_cycles;
	bit       no_idle;

	nur_replacement_policy_top #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.action      (action),
		.block_index (block_index),
		.valid_bit   (valid_bit),
		.dirty_bit   (dirty_bit),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.victim_index(victim_index),
		.victim_found(victim_found),
		.period_reset(period_reset),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// lowest invalid block, else lowest block of the smallest weight 2r+m
	function automatic logic [BLOCK_W-1:0] choose_victim();
		for (int i = 0; i < NUM_BLOCKS; i++)
			if (!shadow_valid[i])
				return BLOCK_W'(i);
		for (int w = 0; w < 4; w++)
			for (int i = 0; i < NUM_BLOCKS; i++)
				if ({shadow_ref[i], shadow_dirty[i]} == 2'(w))
					return BLOCK_W'(i);
		return '0;
	endfunction

	function automatic outcome_t apply_transaction(input logic [ACTION_W-1:0] act,
			input logic [BLOCK_W-1:0] blk, input logic v, input logic d);
		outcome_t o;
		o = '0;
		case (act)
			ACT_READ, ACT_WRITE: begin
				if (shadow_period == '0) begin
					if (shadow_count != COUNT_MAX)
						shadow_count = shadow_count + 1'b1;
				end else begin
					shadow_count = shadow_count + 1'b1;
					if (shadow_count == shadow_period) begin
						shadow_ref     = '0;
						shadow_count   = '0;
						o.period_reset = 1'b1;
					end
				end
				shadow_ref[blk] = 1'b1;
			end
			ACT_REPLACE: begin
				o.victim_index = choose_victim();
				o.victim_found = 1'b1;
			end
			ACT_INVALIDATE: begin
				if (shadow_period != '0) begin
					shadow_ref     = '0;
					shadow_count   = '0;
					o.period_reset = 1'b1;
				end
			end
			ACT_STATUS: begin
				shadow_valid[blk] = v;
				shadow_dirty[blk] = d;
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BLOCK_W-1:0] blk,
			input logic v, input logic d);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid  <= 1'b1;
		action      <= act;
		block_index <= blk;
		valid_bit   <= v;
		dirty_bit   <= d;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		outcome_q.push_back(apply_transaction(act, blk, v, d));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write deref_period, then read it back
	task automatic set_deref_period(input logic [COUNT_W-1:0] value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_DEREF_PERIOD;
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		shadow_period = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {16'h0000, shadow_period}) begin
			$error("prdata expected %0h got %0h", {16'h0000, shadow_period}, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_access(input logic [BLOCK_W-1:0] blk);
		send_item($urandom_range(1) ? ACT_WRITE : ACT_READ, blk, 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic test_reset_and_actions();
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		send_item(ACT_STATUS, 6'd63, 1'b1, 1'b1);
		send_item(ACT_STATUS, 6'd0, 1'b1, 1'b0);
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		send_item(ACT_READ, 6'd0, 1'b0, 1'b0);
		send_item(ACT_WRITE, 6'd63, 1'b1, 1'b1);
		// zero period: invalidate leaves everything alone
		send_item(ACT_INVALIDATE, 6'd0, 1'b0, 1'b0);
		send_item(ACT_UNUSED_FIRST, 6'd63, 1'b1, 1'b1);
		send_item(ACT_UNUSED_FIRST + 3'd1, 6'd21, 1'b0, 1'b1);
		send_item(ACT_UNUSED_FIRST + 3'd2, 6'd42, 1'b1, 1'b0);
		send_item(ACT_STATUS, 6'd1, 1'b0, 1'b1);
		send_item(ACT_STATUS, 6'd0, 1'b0, 1'b0);
		send_item(ACT_REPLACE, 6'd63, 1'b1, 1'b1);
	endtask

	task automatic test_period_clearing();
		set_deref_period(16'd3);
		send_item(ACT_READ, 6'd5, 1'b0, 1'b0);
		send_item(ACT_WRITE, 6'd6, 1'b0, 1'b0);
		send_item(ACT_READ, 6'd7, 1'b0, 1'b0);
		send_item(ACT_READ, 6'd8, 1'b0, 1'b0);
		send_item(ACT_INVALIDATE, 6'd0, 1'b0, 1'b0);
		set_deref_period(16'd1);
		send_item(ACT_WRITE, 6'd9, 1'b0, 1'b0);
		send_item(ACT_READ, 6'd10, 1'b0, 1'b0);
	endtask

	// count with clearing off, lower the period below the count, then catch up to a new one
	task automatic test_counter_limits();
		set_deref_period(16'd0);
		no_idle = 1'b1;
		for (int i = 0; i < 100; i++)
			send_access(6'($urandom_range(63)));
		no_idle = 1'b0;
		set_deref_period(16'd40);
		repeat (4) send_access(6'($urandom_range(63)));
		set_deref_period(16'd106);
		send_access(6'($urandom_range(63)));
		send_access(6'($urandom_range(63)));
	endtask

	task automatic test_weight_order();
		set_deref_period(16'd0);
		for (int i = 0; i < NUM_BLOCKS; i++)
			send_item(ACT_STATUS, 6'(i), 1'b1, 1'b1);
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		for (int i = 0; i < NUM_BLOCKS; i++)
			send_access(6'(i));
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		send_item(ACT_STATUS, 6'd40, 1'b1, 1'b0);
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		set_deref_period(16'd100);
		send_item(ACT_INVALIDATE, 6'd0, 1'b0, 1'b0);
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
		send_access(6'd40);
		send_item(ACT_REPLACE, 6'd0, 1'b0, 1'b0);
	endtask

	task automatic random_phase(input int count, input int valid_pct, input bit pause_midway);
		int sent;
		int roll;
		sent = 0;
		while (sent < count) begin
			if (pause_midway && sent == count / 2)
				wait_drained();
			roll = $urandom_range(99);
			if (roll < 30) begin
				send_access(6'($urandom_range(63)));
				sent++;
			end else if (roll < 55) begin
				send_item(ACT_STATUS, 6'($urandom_range(63)), $urandom_range(99) < valid_pct,
					1'($urandom_range(1)));
				sent++;
			end else if (roll < 85) begin
				send_item(ACT_REPLACE, 6'($urandom_range(63)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else if (roll < 95) begin
				send_item(ACT_INVALIDATE, 6'($urandom_range(63)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				send_item(ACT_UNUSED_FIRST + 3'($urandom_range(2)), 6'($urandom_range(63)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_deref_period(16'd4);
		random_phase(200, 95, 1'b1);
		set_deref_period(16'($urandom_range(2, 20)));
		random_phase(200, 90, 1'b0);
		set_deref_period(16'd0);
		random_phase(200, 97, 1'b0);
		set_deref_period(16'hFFFF);
		random_phase(200, 60, 1'b1);
		set_deref_period(16'($urandom_range(65535)));
		random_phase(200, 92, 1'b0);
	endtask

	always @(posedge clk) begin
		result_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (outcome_q.size() == 0) begin
				$error("result with no transaction pending");
				fail_count++;
			end else begin
				oldest = outcome_q.pop_front();
				if (victim_index !== oldest.victim_index) begin
					$error("victim_index expected %0d got %0d", oldest.victim_index,
						victim_index);
					fail_count++;
				end
				if (victim_found !== oldest.victim_found) begin
					$error("victim_found expected %0d got %0d", oldest.victim_found,
						victim_found);
					fail_count++;
				end
				if (period_reset !== oldest.period_reset) begin
					$error("period_reset expected %0d got %0d", oldest.period_reset,
						period_reset);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		fail_count    = 0;
		stall_cycles  = 0;
		no_idle       = 1'b0;
		shadow_valid  = '0;
		shadow_dirty  = '0;
		shadow_ref    = '0;
		shadow_count  = '0;
		shadow_period = '0;
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		action       <= ACT_READ;
		block_index  <= '0;
		valid_bit    <= 1'b0;
		dirty_bit    <= 1'b0;
		result_ready <= 1'b0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_actions();
		test_period_clearing();
		test_counter_limits();
		test_weight_order();
		test_random_traffic();

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
